/* hdl/per_marker_pose_kalman_smoother_top_defines.svh */
// Assertion macros for the marker pose smoother.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef PER_MARKER_POSE_KALMAN_SMOOTHER_TOP_DEFINES_SVH
`define PER_MARKER_POSE_KALMAN_SMOOTHER_TOP_DEFINES_SVH

// Generic clocked check, disabled while reset is asserted.
`define PMPKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Check on the block clock and reset.
`define PMPKS_ASSERT_BLK(lbl, prop) \
  `PMPKS_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

/* hdl/pmpks_pkg.sv */
// Shared types and constants of the marker pose smoother.
// No dependencies; used by the top level by scoped names.
package pmpks_pkg;

  localparam int unsigned NumSlotsDefault = 4;
  localparam int unsigned IdRegs          = 4;

  localparam logic [23:0] ProcessNoiseReset     = 24'd19661;
  localparam logic [23:0] MeasurementNoiseReset = 24'd196608;
  localparam logic [15:0] KnownIdReset [IdRegs] = '{16'd54, 16'd55, 16'd53, 16'd57};

  localparam logic [31:0] VarOne  = 32'd65536;
  localparam logic [16:0] GainOne = 17'd65536;
  localparam logic [15:0] QuatOne = 16'd16384;

  // configuration register indexes
  localparam logic [2:0] CfgProcessNoise     = 3'd0;
  localparam logic [2:0] CfgMeasurementNoise = 3'd1;
  localparam logic [2:0] CfgKnownId0         = 3'd2;
  localparam logic [2:0] CfgKnownId1         = 3'd3;
  localparam logic [2:0] CfgKnownId2         = 3'd4;
  localparam logic [2:0] CfgKnownId3         = 3'd5;

  typedef struct packed {
    logic        [15:0] meas_tag;
    logic signed [31:0] meas_pos_x;
    logic signed [31:0] meas_pos_y;
    logic signed [31:0] meas_pos_z;
    logic signed [15:0] meas_quat_x;
    logic signed [15:0] meas_quat_y;
    logic signed [15:0] meas_quat_z;
    logic signed [15:0] meas_quat_w;
  } in_item_t;

  typedef struct packed {
    logic        [15:0] filt_tag;
    logic signed [31:0] filt_pos_x;
    logic signed [31:0] filt_pos_y;
    logic signed [31:0] filt_pos_z;
    logic signed [15:0] filt_quat_x;
    logic signed [15:0] filt_quat_y;
    logic signed [15:0] filt_quat_z;
    logic signed [15:0] filt_quat_w;
  } out_item_t;

endpackage

/* hdl/per_marker_pose_kalman_smoother_top.sv */
// Marker pose smoother: per-slot scalar Kalman filter on position and quaternion.
// Depends on pmpks_pkg and per_marker_pose_kalman_smoother_top_defines.svh.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------
//  in      | in  | in_valid_i/stall_o  | pmpks_pkg::in_item_t
//  out     | out | out_valid_o/stall_i | pmpks_pkg::out_item_t
//  cfg     | in  | cfg_valid_i/ready_o | cfg_index_i (3b), cfg_data_i (24b)
//
// A known id runs the gain division on the shared restoring divider, then two
// quaternion normalizations (a square root and four divisions on the same
// divider each); a zero-length quaternion skips the normalization. An unknown
// id is dropped in the transfer cycle.
// Reset clears slot use flags and control and loads the config defaults; slot data needs no clearing.
// in_stall_o is high while an item is in work; a stalled result holds it in
// its last state until the output register is free.
`include "per_marker_pose_kalman_smoother_top_defines.svh"

module per_marker_pose_kalman_smoother_top #(
  parameter int unsigned NUM_SLOTS = pmpks_pkg::NumSlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pmpks_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pmpks_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DIVK, S_POS_M, S_POS_A, S_SQ_M, S_SQ_A, S_SQRT,
    S_QINIT, S_QDIV, S_QFIN, S_QUPD_M, S_QUPD_A, S_VAR_M, S_VAR_A, S_WB, S_DONE
  } state_e;

  state_e state_q;

  logic [23:0] q_noise_q, r_noise_q;
  logic [15:0] known_id_q [pmpks_pkg::IdRegs];

  logic [NUM_SLOTS-1:0]  used_q;
  logic signed [31:0]    pos_mem_q [NUM_SLOTS][3];
  logic signed [15:0]    ori_mem_q [NUM_SLOTS][4];
  logic [31:0]           var_mem_q [NUM_SLOTS];

  logic [SlotW-1:0]      slot_q;
  logic [15:0]           id_q;
  logic signed [31:0]    z_q [3];
  logic signed [31:0]    x_q [3];
  logic signed [15:0]    xq_q [4];
  logic signed [15:0]    vec_q [4];
  logic [31:0]           pp_q, var_new_q;
  logic [16:0]           k_q;
  logic [32:0]           sum_q;
  logic [1:0]            idx_q;
  logic                  pass_q;

  logic [32:0] div_rem_q, div_den_q;
  logic [16:0] div_low_q, div_quo_q;
  logic [4:0]  div_cnt_q;

  logic [60:0] sq_n_q, sq_res_q, sq_bit_q;

  logic signed [51:0] prod_q;
  logic                 out_valid_q;
  pmpks_pkg::out_item_t out_q;

  // ---------------- id match ----------------
  logic             hit;
  logic [SlotW-1:0] hit_slot;
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int j = pmpks_pkg::IdRegs - 1; j >= 0; j--) begin
      if (j < NUM_SLOTS && known_id_q[j] == in_item_i.meas_tag) begin
        hit      = 1'b1;
        hit_slot = SlotW'(j);
      end
    end
  end

  logic in_xfer;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------- load values ----------------
  logic [31:0] p_sel, pp_sat;
  logic [32:0] p_sum, den;
  always_comb begin
    p_sel  = used_q[slot_q] ? var_mem_q[slot_q] : pmpks_pkg::VarOne;
    p_sum  = {1'b0, p_sel} + {9'b0, q_noise_q};
    pp_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    den    = {1'b0, pp_sat} + {9'b0, r_noise_q};
  end

  // ---------------- shared multiplier ----------------
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_d;
  logic signed [32:0] pos_diff;
  logic signed [16:0] quat_diff;
  always_comb begin
    pos_diff  = 33'(z_q[idx_q]) - 33'(x_q[idx_q]);
    quat_diff = 17'(vec_q[idx_q]) - 17'(xq_q[idx_q]);
    case (state_q)
      S_POS_M:  begin mul_a = 34'(pos_diff);     mul_b = $signed({1'b0, k_q}); end
      S_SQ_M:   begin mul_a = 34'(vec_q[idx_q]); mul_b = 18'(vec_q[idx_q]);   end
      S_QUPD_M: begin mul_a = 34'(quat_diff);    mul_b = $signed({1'b0, k_q}); end
      S_VAR_M:  begin
        mul_a = $signed({2'b0, pp_q});
        mul_b = $signed({1'b0, pmpks_pkg::GainOne - k_q});
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    prod_d = mul_a * mul_b;
  end

  logic signed [51:0] rnd;
  assign rnd = (prod_q + 52'sd32768) >>> 16;

  // ---------------- divider step ----------------
  logic [33:0] div_t;
  logic        div_ge;
  logic [32:0] div_rem_n;
  logic [16:0] div_quo_n;
  always_comb begin
    div_t     = {div_rem_q, div_low_q[16]};
    div_ge    = div_t >= {1'b0, div_den_q};
    div_rem_n = div_ge ? 33'(div_t - {1'b0, div_den_q}) : div_t[32:0];
    div_quo_n = {div_quo_q[15:0], div_ge};
  end

  // ---------------- square root step ----------------
  logic [60:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_res_q + sq_bit_q;
  assign sq_ge = sq_n_q >= sq_t;

  // ---------------- normalize helpers ----------------
  logic [32:0] sum_d;
  logic [15:0] q_mag;
  logic [43:0] q_num;
  logic [15:0] q_res;
  assign sum_d = sum_q + {2'b0, prod_q[30:0]};
  assign q_mag = vec_q[idx_q][15] ? 16'(-vec_q[idx_q]) : vec_q[idx_q];
  assign q_num = {q_mag, 28'b0} + {14'b0, sq_res_q[30:1]};
  assign q_res = (div_quo_q[15:0] > pmpks_pkg::QuatOne) ? pmpks_pkg::QuatOne
                                                        : div_quo_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      q_noise_q   <= pmpks_pkg::ProcessNoiseReset;
      r_noise_q   <= pmpks_pkg::MeasurementNoiseReset;
      for (int j = 0; j < pmpks_pkg::IdRegs; j++) begin
        known_id_q[j] <= pmpks_pkg::KnownIdReset[j];
      end
      idx_q  <= '0;
      pass_q <= 1'b0;
    end else begin
      prod_q <= prod_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pmpks_pkg::CfgProcessNoise:     q_noise_q     <= cfg_data_i;
          pmpks_pkg::CfgMeasurementNoise: r_noise_q     <= cfg_data_i;
          pmpks_pkg::CfgKnownId0:         known_id_q[0] <= cfg_data_i[15:0];
          pmpks_pkg::CfgKnownId1:         known_id_q[1] <= cfg_data_i[15:0];
          pmpks_pkg::CfgKnownId2:         known_id_q[2] <= cfg_data_i[15:0];
          pmpks_pkg::CfgKnownId3:         known_id_q[3] <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // load a new result, or drop the flag once the result transfers
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer && hit) begin
            slot_q   <= hit_slot;
            id_q     <= in_item_i.meas_tag;
            z_q[0]   <= in_item_i.meas_pos_x;
            z_q[1]   <= in_item_i.meas_pos_y;
            z_q[2]   <= in_item_i.meas_pos_z;
            vec_q[0] <= in_item_i.meas_quat_x;
            vec_q[1] <= in_item_i.meas_quat_y;
            vec_q[2] <= in_item_i.meas_quat_z;
            vec_q[3] <= in_item_i.meas_quat_w;
            state_q  <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            x_q[i] <= used_q[slot_q] ? pos_mem_q[slot_q][i] : 32'sd0;
          end
          for (int i = 0; i < 4; i++) begin
            xq_q[i] <= used_q[slot_q] ? ori_mem_q[slot_q][i] : 16'sd0;
          end
          used_q[slot_q] <= 1'b1;
          pp_q  <= pp_sat;
          idx_q <= '0;
          if (den == '0) begin
            k_q     <= '0;
            state_q <= S_POS_M;
          end else begin
            div_rem_q <= {2'b0, pp_sat[31:1]};
            div_low_q <= {pp_sat[0], 16'b0};
            div_den_q <= den;
            div_quo_q <= '0;
            div_cnt_q <= 5'd17;
            state_q   <= S_DIVK;
          end
        end
        S_DIVK, S_QDIV: begin
          div_rem_q <= div_rem_n;
          div_low_q <= {div_low_q[15:0], 1'b0};
          div_quo_q <= div_quo_n;
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == 5'd1) begin
            if (state_q == S_DIVK) begin
              k_q     <= div_quo_n;
              state_q <= S_POS_M;
            end else begin
              state_q <= S_QFIN;
            end
          end
        end
        S_POS_M: state_q <= S_POS_A;
        S_POS_A: begin
          x_q[idx_q] <= x_q[idx_q] + rnd[31:0];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            sum_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= S_SQ_M;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_POS_M;
          end
        end
        S_SQ_M: state_q <= S_SQ_A;
        S_SQ_A: begin
          sum_q <= sum_d;
          if (idx_q == 2'd3) begin
            idx_q <= '0;
            if (sum_d == '0) begin
              // zero-length quaternion: leave it as it is
              state_q <= pass_q ? S_VAR_M : S_QUPD_M;
            end else begin
              sq_n_q   <= {sum_d, 28'b0};
              sq_res_q <= '0;
              sq_bit_q <= 61'd1 << 60;
              state_q  <= S_SQRT;
            end
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_SQ_M;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n_q   <= sq_n_q - sq_t;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            state_q <= S_QINIT;
          end
        end
        S_QINIT: begin
          div_rem_q <= {5'b0, q_num[43:16]};
          div_low_q <= {q_num[15:0], 1'b0};
          div_den_q <= {2'b0, sq_res_q[30:0]};
          div_quo_q <= '0;
          div_cnt_q <= 5'd16;
          state_q   <= S_QDIV;
        end
        S_QFIN: begin
          vec_q[idx_q] <= vec_q[idx_q][15] ? -$signed(q_res) : $signed(q_res);
          if (idx_q == 2'd3) begin
            idx_q   <= '0;
            state_q <= pass_q ? S_VAR_M : S_QUPD_M;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_QINIT;
          end
        end
        S_QUPD_M: state_q <= S_QUPD_A;
        S_QUPD_A: begin
          vec_q[idx_q] <= xq_q[idx_q] + rnd[15:0];
          if (idx_q == 2'd3) begin
            idx_q   <= '0;
            sum_q   <= '0;
            pass_q  <= 1'b1;
            state_q <= S_SQ_M;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_QUPD_M;
          end
        end
        S_VAR_M: state_q <= S_VAR_A;
        S_VAR_A: begin
          var_new_q <= rnd[31:0];
          state_q   <= S_WB;
        end
        S_WB: begin
          for (int i = 0; i < 3; i++) begin
            pos_mem_q[slot_q][i] <= x_q[i];
          end
          for (int i = 0; i < 4; i++) begin
            ori_mem_q[slot_q][i] <= vec_q[i];
          end
          var_mem_q[slot_q] <= var_new_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.filt_tag    <= id_q;
            out_q.filt_pos_x  <= x_q[0];
            out_q.filt_pos_y  <= x_q[1];
            out_q.filt_pos_z  <= x_q[2];
            out_q.filt_quat_x <= vec_q[0];
            out_q.filt_quat_y <= vec_q[1];
            out_q.filt_quat_z <= vec_q[2];
            out_q.filt_quat_w <= vec_q[3];
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PMPKS_ASSERT_BLK(a_used_sticky, (used_q & $past(used_q)) == $past(used_q))
  `PMPKS_ASSERT_BLK(a_gain_range, (state_q == S_POS_M) |-> (k_q <= pmpks_pkg::GainOne))
  `PMPKS_ASSERT_BLK(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
  `PMPKS_ASSERT_BLK(a_quat_bound, out_valid_q |-> (out_q.filt_quat_w <= 16'sd16384 && out_q.filt_quat_w >= -16'sd16384))

endmodule

/* tb/per_marker_pose_kalman_smoother_top_test.sv */
// Testbench of the marker pose smoother: directed table, then random poses
// under several idle and stall patterns. Depends on pmpks_pkg and the top level.
`timescale 1ns / 100ps

module per_marker_pose_kalman_smoother_top_test;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    pmpks_pkg::in_item_t  stim;
    bit                   typed;
    bit                   has_out;
    pmpks_pkg::out_item_t pose;
  } pose_row_t;

  localparam int DrainCycles = 300;
  // indexes past the last register
  localparam logic [2:0] CfgSpare0 = 3'd6;
  localparam logic [2:0] CfgSpare1 = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  pmpks_pkg::in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pmpks_pkg::out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  per_marker_pose_kalman_smoother_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // filter state kept by the testbench
  logic [23:0] q_noise, r_noise;
  logic [15:0] slot_id [pmpks_pkg::IdRegs];
  bit          used_q [pmpks_pkg::IdRegs];
  logic signed [31:0] pos_q [pmpks_pkg::IdRegs][3];
  logic signed [15:0] ori_q [pmpks_pkg::IdRegs][4];
  logic [31:0] var_q [pmpks_pkg::IdRegs];

  pmpks_pkg::out_item_t pending_poses [$];
  idle_mode_e  idle_mode = IdleNone;
  bit          hold_req = 1'b0;
  int          mismatches = 0;
  bit          failed = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void unit_quat(ref longint v [4]);
    longint unsigned sum, s, mag, m;
    sum = 0;
    for (int i = 0; i < 4; i++) sum += longint'(v[i] * v[i]);
    if (sum == 0) return;
    s = int_sqrt(sum << 28);
    for (int i = 0; i < 4; i++) begin
      mag = v[i] < 0 ? -v[i] : v[i];
      m = ((mag << 28) + (s >> 1)) / s;
      if (m > 16384) m = 16384;
      v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
    end
  endfunction

  // round to nearest, ties up: floor((v + 2^15) / 2^16)
  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic bit filter_pose(pmpks_pkg::in_item_t it,
                                     output pmpks_pkg::out_item_t pose);
    int slot;
    longint unsigned pp, den, k;
    longint z, x;
    longint qv [4];
    slot = -1;
    pose = '0;
    for (int i = pmpks_pkg::IdRegs - 1; i >= 0; i--) if (slot_id[i] == it.meas_tag) slot = i;
    if (slot < 0) return 1'b0;
    if (!used_q[slot]) begin
      used_q[slot] = 1'b1;
      var_q[slot] = 32'd65536;
      for (int i = 0; i < 3; i++) pos_q[slot][i] = '0;
      for (int i = 0; i < 4; i++) ori_q[slot][i] = '0;
    end
    pp = longint'(var_q[slot]) + q_noise;
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    den = pp + r_noise;
    k = (den == 0) ? 0 : (pp << 16) / den;
    for (int i = 0; i < 3; i++) begin
      z = (i == 0) ? it.meas_pos_x : (i == 1) ? it.meas_pos_y : it.meas_pos_z;
      x = pos_q[slot][i];
      x = x + round_q16(longint'(k) * (z - x));
      pos_q[slot][i] = x[31:0];
    end
    qv[0] = it.meas_quat_x;
    qv[1] = it.meas_quat_y;
    qv[2] = it.meas_quat_z;
    qv[3] = it.meas_quat_w;
    unit_quat(qv);
    for (int i = 0; i < 4; i++) begin
      x = ori_q[slot][i];
      qv[i] = x + round_q16(longint'(k) * (qv[i] - x));
    end
    unit_quat(qv);
    for (int i = 0; i < 4; i++) ori_q[slot][i] = qv[i][15:0];
    var_q[slot] = 32'((((64'd65536 - k) * pp + 32768) >> 16));
    pose.filt_tag = it.meas_tag;
    pose.filt_pos_x = pos_q[slot][0];
    pose.filt_pos_y = pos_q[slot][1];
    pose.filt_pos_z = pos_q[slot][2];
    pose.filt_quat_x = ori_q[slot][0];
    pose.filt_quat_y = ori_q[slot][1];
    pose.filt_quat_z = ori_q[slot][2];
    pose.filt_quat_w = ori_q[slot][3];
    return 1'b1;
  endfunction

  function automatic pmpks_pkg::in_item_t mk_pose(logic [15:0] id, logic [31:0] px,
      logic [31:0] py, logic [31:0] pz, logic [15:0] qx, logic [15:0] qy,
      logic [15:0] qz, logic [15:0] qw);
    pmpks_pkg::in_item_t it;
    it = '{id, px, py, pz, qx, qy, qz, qw};
    return it;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return pos_q[$urandom_range(pmpks_pkg::IdRegs - 1)][0]
                      + 32'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(2))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic pmpks_pkg::in_item_t rand_item();
    pmpks_pkg::in_item_t it;
    it.meas_tag = ($urandom_range(9) < 8) ? slot_id[$urandom_range(pmpks_pkg::IdRegs - 1)]
                                          : 16'($urandom);
    it.meas_pos_x = rand_pos();
    it.meas_pos_y = rand_pos();
    it.meas_pos_z = rand_pos();
    if ($urandom_range(7) == 0) begin
      {it.meas_quat_x, it.meas_quat_y, it.meas_quat_z, it.meas_quat_w} = '0;
    end else begin
      it.meas_quat_x = rand_quat();
      it.meas_quat_y = rand_quat();
      it.meas_quat_z = rand_quat();
      it.meas_quat_w = rand_quat();
    end
    return it;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pmpks_pkg::CfgProcessNoise:     q_noise = data;
      pmpks_pkg::CfgMeasurementNoise: r_noise = data;
      pmpks_pkg::CfgKnownId0:         slot_id[0] = data[15:0];
      pmpks_pkg::CfgKnownId1:         slot_id[1] = data[15:0];
      pmpks_pkg::CfgKnownId2:         slot_id[2] = data[15:0];
      pmpks_pkg::CfgKnownId3:         slot_id[3] = data[15:0];
      default: ;
    endcase
    // cfg_valid_i stays low before the next write
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // offer one pose; typed rows supply their own expectation
  task automatic send_pose(pmpks_pkg::in_item_t it, bit typed, bit has_out,
                           pmpks_pkg::out_item_t typed_pose);
    pmpks_pkg::out_item_t pose;
    bit hit;
    int gap;
    gap = 0;
    if (idle_mode == IdleSender && $urandom_range(99) < 66) gap = $urandom_range(1, 8);
    if (idle_mode == IdleBoth && $urandom_range(99) < 17) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    hit = filter_pose(it, pose);
    if (typed) begin
      if (has_out) pending_poses = {pending_poses, typed_pose};
    end else if (hit) begin
      pending_poses = {pending_poses, pose};
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 3000;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == IdleReceiver) begin
        out_stall_i <= ($urandom_range(99) < 66);
      end else if (idle_mode == IdleBoth) begin
        out_stall_i <= ($urandom_range(99) < 17);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pmpks_pkg::out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_poses.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %h", out_item_o);
      end else begin
        want = pending_poses.pop_front();
        if (out_item_o !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("pose mismatch: expected %h actual %h", want, out_item_o);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    pose_row_t rows [$];
    pose_row_t row;
    pmpks_pkg::out_item_t no_pose;
    logic [23:0] q_set [6];
    logic [23:0] r_set [6];
    no_pose = '0;
    q_noise = pmpks_pkg::ProcessNoiseReset;
    r_noise = pmpks_pkg::MeasurementNoiseReset;
    for (int i = 0; i < pmpks_pkg::IdRegs; i++) begin
      slot_id[i] = pmpks_pkg::KnownIdReset[i];
      used_q[i] = 1'b0;
      var_q[i] = pmpks_pkg::VarOne;
      for (int j = 0; j < 3; j++) pos_q[i][j] = '0;
      for (int j = 0; j < 4; j++) ori_q[i][j] = '0;
    end

    // first use: unit quaternion stays unit, zero position stays zero
    row = '{mk_pose(54, 0, 0, 0, 0, 0, 0, 16384), 1, 1, '{54, 0, 0, 0, 0, 0, 0, 16384}};
    rows = {rows, row};
    // zero-length quaternion stays zero
    row = '{mk_pose(55, 0, 0, 0, 0, 0, 0, 0), 1, 1, '{55, 0, 0, 0, 0, 0, 0, 0}};
    rows = {rows, row};
    // unknown ids: dropped
    row = '{mk_pose(0, 32'h7FFF_FFFF, 1, 2, 3, 4, 5, 6), 1, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(16'hFFFF, 32'h8000_0000, 1, 2, 3, 4, 5, 6), 1, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(53, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(57, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                    16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(54, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(54, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    16'h8000, 0, 0, 0), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(55, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                    0, 0, 0, 0), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(53, 0, 0, 0, 0, 0, 0, 0), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(57, 1, -1, 0, 0, 16384, 0, 0), 0, 0, no_pose};
    rows = {rows, row};
    row = '{mk_pose(56, 0, 0, 0, 0, 0, 0, 16384), 0, 0, no_pose};
    rows = {rows, row};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pose(rows[i].stim, rows[i].typed, rows[i].has_out, rows[i].pose);

    // phases: reset setting first, then extremes of q and r, then random
    q_set = '{pmpks_pkg::ProcessNoiseReset, 24'd0, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF,
              24'($urandom)};
    r_set = '{pmpks_pkg::MeasurementNoiseReset, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0,
              24'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        wait_idle();
        write_reg(pmpks_pkg::CfgProcessNoise, q_set[ph]);
        write_reg(pmpks_pkg::CfgMeasurementNoise, r_set[ph]);
        case (ph)
          1: begin
            // duplicate ids: lowest slot wins
            write_reg(pmpks_pkg::CfgKnownId0, 24'd7);
            write_reg(pmpks_pkg::CfgKnownId1, 24'd7);
            write_reg(pmpks_pkg::CfgKnownId2, 24'd0);
            write_reg(pmpks_pkg::CfgKnownId3, 24'hFFFF);
          end
          2: begin
            write_reg(pmpks_pkg::CfgKnownId0, 24'hFFFF);
            write_reg(pmpks_pkg::CfgKnownId1, 24'd55);
            write_reg(pmpks_pkg::CfgKnownId2, 24'd0);
            write_reg(pmpks_pkg::CfgKnownId3, 24'd7);
          end
          default: begin
            for (int i = 0; i < pmpks_pkg::IdRegs; i++) begin
              write_reg(pmpks_pkg::CfgKnownId0 + 3'(i), 24'($urandom));
            end
          end
        endcase
        // indexes past the last register are ignored
        write_reg(CfgSpare0, 24'($urandom));
        write_reg(CfgSpare1, 24'($urandom));
      end
      for (int n = 0; n < 315; n++) begin
        idle_mode = idle_mode_e'((n / 40 + ph) % 4);
        if (ph == 0 && n == 60) hold_req = 1'b1;
        send_pose(rand_item(), 0, 0, no_pose);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/pmpks_pkg.sv
hdl/per_marker_pose_kalman_smoother_top.sv
tb/per_marker_pose_kalman_smoother_top_test.sv
